// File: hdl/vna_pkg.sv
package vna_pkg;

  localparam int unsigned VERTICES_DEF      = 1024;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned ACCUM_BITS_DEF    = 48;
  localparam int unsigned IDX_W             = 10;
  localparam int unsigned IN_POS_W          = 16;
  localparam int unsigned NRM_W             = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic                  in_range;
    logic [IDX_W-1:0]      va;
    logic [IDX_W-1:0]      vb;
    logic [IDX_W-1:0]      vc;
    logic [IN_POS_W-1:0]   px;
    logic [IN_POS_W-1:0]   py;
    logic [IN_POS_W-1:0]   pz;
  } job_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_PA, ST_PB, ST_PC, ST_PWAIT,
    ST_MUL, ST_CROSS,
    ST_RMW_RD, ST_RMW_WAIT, ST_RMW_WR,
    ST_RD, ST_RDWAIT,
    ST_NSCAN, ST_NSHIFT, ST_NSQ, ST_NSUM,
    ST_SQRT, ST_DIV, ST_DIVNEXT,
    ST_OUT
  } st_e;

endpackage

// File: hdl/vna_ram.sv
module vna_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/vna_front.sv
module vna_front #(
  parameter int unsigned VERTICES = vna_pkg::VERTICES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [1:0]                  command_i,
  input  logic [vna_pkg::IDX_W-1:0]   vertex_a_i,
  input  logic [vna_pkg::IDX_W-1:0]   vertex_b_i,
  input  logic [vna_pkg::IDX_W-1:0]   vertex_c_i,
  input  logic [vna_pkg::IN_POS_W-1:0] pos_x_i,
  input  logic [vna_pkg::IN_POS_W-1:0] pos_y_i,
  input  logic [vna_pkg::IN_POS_W-1:0] pos_z_i,
  output logic                        job_valid_o,
  output vna_pkg::job_t               job_o,
  input  logic                        job_take_i
);

  localparam int unsigned DEPTH = 2;

  vna_pkg::job_t q_q [DEPTH];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;
  vna_pkg::job_t nj;
  logic          ra, rb, rc;

  always_comb begin
    ra = 32'(vertex_a_i) < VERTICES;
    rb = 32'(vertex_b_i) < VERTICES;
    rc = 32'(vertex_c_i) < VERTICES;
    nj.cmd = vna_pkg::cmd_e'(command_i);
    nj.in_range = (vna_pkg::cmd_e'(command_i) == vna_pkg::CMD_TRI) ? (ra && rb && rc) : ra;
    nj.va = vertex_a_i;
    nj.vb = vertex_b_i;
    nj.vc = vertex_c_i;
    nj.px = pos_x_i;
    nj.py = pos_y_i;
    nj.pz = pos_z_i;
  end

  assign stall_o     = (cnt_q == 2'(DEPTH));
  assign push        = valid_i && !stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_take_i;
  assign job_o       = q_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= nj;
    end
  end

endmodule

// File: hdl/vna_back.sv
module vna_back #(
  parameter int unsigned VERTICES      = vna_pkg::VERTICES_DEF,
  parameter int unsigned POSITION_BITS = vna_pkg::POSITION_BITS_DEF,
  parameter int unsigned ACCUM_BITS    = vna_pkg::ACCUM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  vna_pkg::job_t                job_i,
  output logic                         job_take_o,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [vna_pkg::NRM_W-1:0]    normal_x_o,
  output logic [vna_pkg::NRM_W-1:0]    normal_y_o,
  output logic [vna_pkg::NRM_W-1:0]    normal_z_o,
  output logic                         is_read_data_o,
  output logic                         zero_length_o
);

  localparam int unsigned AW  = $clog2(VERTICES);
  localparam int unsigned PB  = POSITION_BITS;
  localparam int unsigned DB  = PB + 1;
  localparam int unsigned PRB = 2 * DB;
  localparam int unsigned CB  = PRB + 1;
  localparam int unsigned A   = ACCUM_BITS;
  localparam int unsigned SW  = 3 * A;
  localparam int unsigned MB  = 30;
  localparam int unsigned SQB = 2 * MB + 2;
  localparam int unsigned RB  = MB + 1;
  localparam int unsigned NB  = MB + 16;
  localparam int unsigned SHW = $clog2(A + MB + 1);
  localparam logic [A-1:0] AMAX = {1'b0, {(A-1){1'b1}}};
  localparam logic [A-1:0] AMIN = {1'b1, {(A-1){1'b0}}};

  vna_pkg::st_e st_q, st_d;
  vna_pkg::job_t job_q;

  // position and sum memories, with an epoch tag on each sum entry
  logic             pw_e;
  logic [AW-1:0]    pw_a, pr_a;
  logic [3*PB-1:0]  pw_d, pr_d;
  logic             sw_e;
  logic [AW-1:0]    sw_a, sr_a;
  logic [SW:0]      sw_d, sr_d;
  logic             ep_q;

  vna_ram #(.WIDTH(3*PB), .DEPTH(VERTICES)) u_pos (
    .clk_i, .we_i(pw_e), .waddr_i(pw_a), .wdata_i(pw_d), .raddr_i(pr_a), .rdata_o(pr_d));
  vna_ram #(.WIDTH(SW+1), .DEPTH(VERTICES)) u_sum (
    .clk_i, .we_i(sw_e), .waddr_i(sw_a), .wdata_i(sw_d), .raddr_i(sr_a), .rdata_o(sr_d));

  // clear uses epoch bit plus a sweep so stale tags never alias
  logic [AW:0] clr_q;

  logic signed [PB-1:0] pa_q [3];
  logic signed [PB-1:0] pbv_q [3];
  logic signed [DB-1:0] u_q [3], v_q [3];
  logic signed [PRB-1:0] pr_q [6];
  logic signed [CB-1:0] n_q [3];
  logic [1:0] k_q;
  logic signed [A-1:0] acc_q [3];

  logic [A-1:0] mag_q [3];
  logic [A-1:0] big_q;
  logic [MB-1:0] m_q [3];
  logic [SQB-1:0] sq_q [3];
  logic [SQB+1:0] ssum_q;
  logic [SQB+1:0] rem_q;
  logic [RB-1:0] root_q;
  logic [5:0] it_q;
  logic [NB-1:0] dn_q, dr_q;
  logic [15:0] qt_q;
  logic [1:0] ci_q;
  logic [15:0] res_q [3];
  logic zl_q;
  logic [2:0] neg_q;

  logic ov_q;
  logic [vna_pkg::NRM_W-1:0] ox_q, oy_q, oz_q;
  logic oread_q, ozl_q;

  assign valid_o        = ov_q;
  assign normal_x_o     = ox_q;
  assign normal_y_o     = oy_q;
  assign normal_z_o     = oz_q;
  assign is_read_data_o = oread_q;
  assign zero_length_o  = ozl_q;

  function automatic logic [SHW-1:0] msb_of(input logic [A-1:0] v);
    logic [SHW-1:0] r;
    r = '0;
    for (int i = 0; i < A; i++) begin
      if (v[i]) r = SHW'(i);
    end
    return r;
  endfunction

  function automatic logic signed [A-1:0] sat_add(input logic signed [A-1:0] a,
                                                   input logic signed [CB-1:0] b);
    logic signed [A:0] s;
    s = {a[A-1], a} + (A+1)'(b);
    if (s[A] != s[A-1]) return s[A] ? AMIN : AMAX;
    return s[A-1:0];
  endfunction

  function automatic logic [A-1:0] magv(input logic signed [A-1:0] v);
    return v[A-1] ? A'(-v) : v;
  endfunction

  logic [AW-1:0] idx_k;
  always_comb begin
    case (k_q)
      2'd0:    idx_k = job_q.va[AW-1:0];
      2'd1:    idx_k = job_q.vb[AW-1:0];
      default: idx_k = job_q.vc[AW-1:0];
    endcase
  end

  logic out_free;
  assign out_free = !ov_q || !stall_i;
  logic done_nr;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      vna_pkg::ST_IDLE: begin
        if (!clr_q[AW]) begin
          st_d = vna_pkg::ST_CLR;
        end else if (job_valid_i) begin
          case (job_i.cmd)
            vna_pkg::CMD_TRI:   st_d = job_i.in_range ? vna_pkg::ST_PA : vna_pkg::ST_OUT;
            vna_pkg::CMD_READ:  st_d = job_i.in_range ? vna_pkg::ST_RD : vna_pkg::ST_OUT;
            vna_pkg::CMD_CLEAR: st_d = vna_pkg::ST_OUT;
            default:            st_d = vna_pkg::ST_OUT;
          endcase
        end
      end
      vna_pkg::ST_CLR:     st_d = (clr_q[AW-1:0] == AW'(VERTICES-1)) ? vna_pkg::ST_IDLE
                                                                    : vna_pkg::ST_CLR;
      vna_pkg::ST_PA:      st_d = vna_pkg::ST_PB;
      vna_pkg::ST_PB:      st_d = vna_pkg::ST_PC;
      vna_pkg::ST_PC:      st_d = vna_pkg::ST_PWAIT;
      vna_pkg::ST_PWAIT:   st_d = vna_pkg::ST_MUL;
      vna_pkg::ST_MUL:     st_d = vna_pkg::ST_CROSS;
      vna_pkg::ST_CROSS:   st_d = vna_pkg::ST_RMW_RD;
      vna_pkg::ST_RMW_RD:  st_d = vna_pkg::ST_RMW_WAIT;
      vna_pkg::ST_RMW_WAIT: st_d = vna_pkg::ST_RMW_WR;
      vna_pkg::ST_RMW_WR:  st_d = (k_q == 2'd2) ? vna_pkg::ST_OUT : vna_pkg::ST_RMW_RD;
      vna_pkg::ST_RD:      st_d = vna_pkg::ST_RDWAIT;
      vna_pkg::ST_RDWAIT:  st_d = vna_pkg::ST_NSCAN;
      vna_pkg::ST_NSCAN:   st_d = (big_q == '0) ? vna_pkg::ST_OUT : vna_pkg::ST_NSHIFT;
      vna_pkg::ST_NSHIFT:  st_d = vna_pkg::ST_NSQ;
      vna_pkg::ST_NSQ:     st_d = vna_pkg::ST_NSUM;
      vna_pkg::ST_NSUM:    st_d = vna_pkg::ST_SQRT;
      vna_pkg::ST_SQRT:    st_d = (it_q == 6'd0) ? vna_pkg::ST_DIV : vna_pkg::ST_SQRT;
      vna_pkg::ST_DIV:     st_d = done_nr ? vna_pkg::ST_DIVNEXT : vna_pkg::ST_DIV;
      vna_pkg::ST_DIVNEXT: st_d = (ci_q == 2'd2) ? vna_pkg::ST_OUT : vna_pkg::ST_DIV;
      vna_pkg::ST_OUT:     st_d = out_free ? vna_pkg::ST_IDLE : vna_pkg::ST_OUT;
      default:             st_d = vna_pkg::ST_IDLE;
    endcase
  end

  assign done_nr = (it_q == 6'd0);

  // outputs to memories and queue
  logic signed [A-1:0] cur_sum [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur_sum[i] = (sr_d[SW] == ep_q) ? sr_d[i*A +: A] : '0;
    end
  end

  always_comb begin
    job_take_o = (st_q == vna_pkg::ST_IDLE) && job_valid_i && clr_q[AW];
    pw_e = job_take_o && (job_i.cmd == vna_pkg::CMD_WRITE) && job_i.in_range;
    pw_a = job_i.va[AW-1:0];
    pw_d = {job_i.pz[PB-1:0], job_i.py[PB-1:0], job_i.px[PB-1:0]};
    pr_a = job_q.va[AW-1:0];
    case (st_q)
      vna_pkg::ST_PB: pr_a = job_q.vb[AW-1:0];
      vna_pkg::ST_PC: pr_a = job_q.vc[AW-1:0];
      default:        pr_a = job_q.va[AW-1:0];
    endcase
    sr_a = (st_q == vna_pkg::ST_RMW_RD) ? idx_k : job_q.va[AW-1:0];
    sw_e = 1'b0;
    sw_a = idx_k;
    sw_d = {ep_q, acc_q[2], acc_q[1], acc_q[0]};
    if (st_q == vna_pkg::ST_CLR) begin
      sw_e = 1'b1;
      sw_a = clr_q[AW-1:0];
      sw_d = {ep_q, {SW{1'b0}}};
    end else if (st_q == vna_pkg::ST_RMW_WR) begin
      sw_e = 1'b1;
    end
  end

  logic [SQB+1:0] trial;
  logic [SQB+1:0] rem_sh;
  logic           sq_ge;
  logic [NB:0]    dtrial;
  always_comb begin
    trial  = {(SQB+2-RB-2)'(0), root_q, 2'b01};
    rem_sh = {rem_q[SQB-1:0], ssum_q[SQB+1:SQB]};
    sq_ge  = (rem_sh >= trial);
    dtrial = {1'b0, dn_q} - {1'b0, dr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= vna_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      ep_q    <= 1'b0;
      clr_q   <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == vna_pkg::ST_OUT && out_free) ov_q <= 1'b1;
      else if (!stall_i) ov_q <= 1'b0;
      if (job_take_o && job_i.cmd == vna_pkg::CMD_CLEAR) begin
        ep_q  <= ~ep_q;
        clr_q <= '0;
      end else if (st_q == vna_pkg::ST_CLR) begin
        clr_q <= (clr_q[AW-1:0] == AW'(VERTICES-1)) ? {1'b1, AW'(0)} : clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      vna_pkg::ST_IDLE: begin
        job_q <= job_i;
        k_q <= 2'd0;
        zl_q <= (job_i.cmd == vna_pkg::CMD_READ) && !job_i.in_range;
        for (int i = 0; i < 3; i++) res_q[i] <= '0;
      end
      vna_pkg::ST_PB: for (int i = 0; i < 3; i++) pa_q[i] <= pr_d[i*PB +: PB];
      vna_pkg::ST_PC: for (int i = 0; i < 3; i++) pbv_q[i] <= pr_d[i*PB +: PB];
      vna_pkg::ST_PWAIT: begin
        for (int i = 0; i < 3; i++) begin
          u_q[i] <= DB'(pbv_q[i]) - DB'(pa_q[i]);
          v_q[i] <= DB'($signed(pr_d[i*PB +: PB])) - DB'(pa_q[i]);
        end
      end
      vna_pkg::ST_MUL: begin
        pr_q[0] <= u_q[1] * v_q[2];
        pr_q[1] <= u_q[2] * v_q[1];
        pr_q[2] <= u_q[2] * v_q[0];
        pr_q[3] <= u_q[0] * v_q[2];
        pr_q[4] <= u_q[0] * v_q[1];
        pr_q[5] <= u_q[1] * v_q[0];
      end
      vna_pkg::ST_CROSS: begin
        for (int i = 0; i < 3; i++) n_q[i] <= CB'(pr_q[2*i]) - CB'(pr_q[2*i+1]);
      end
      vna_pkg::ST_RMW_WAIT: begin
        for (int i = 0; i < 3; i++) acc_q[i] <= sat_add(cur_sum[i], n_q[i]);
      end
      vna_pkg::ST_RMW_WR: k_q <= k_q + 2'd1;
      vna_pkg::ST_RDWAIT: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= cur_sum[i][A-1] ? A'(-cur_sum[i]) : cur_sum[i];
          neg_q[i] <= cur_sum[i][A-1];
        end
      end
      vna_pkg::ST_NSCAN: zl_q <= (big_q == '0);
      default: ;
    endcase
    case (st_q)
      vna_pkg::ST_NSHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (msb_of(big_q) > SHW'(MB-1))
            m_q[i] <= MB'(mag_q[i] >> (msb_of(big_q) - SHW'(MB-1)));
          else
            m_q[i] <= MB'(mag_q[i] << (SHW'(MB-1) - msb_of(big_q)));
        end
      end
      vna_pkg::ST_NSQ: for (int i = 0; i < 3; i++) sq_q[i] <= SQB'(m_q[i]) * SQB'(m_q[i]);
      vna_pkg::ST_NSUM: begin
        ssum_q <= (SQB+2)'(sq_q[0]) + (SQB+2)'(sq_q[1]) + (SQB+2)'(sq_q[2]);
        rem_q  <= '0;
        root_q <= '0;
        it_q   <= 6'd32;
      end
      vna_pkg::ST_SQRT: begin
        if (it_q != 6'd0) begin
          ssum_q <= {ssum_q[SQB-1:0], 2'b00};
          rem_q  <= sq_ge ? (rem_sh - trial) : rem_sh;
          root_q <= {root_q[RB-2:0], sq_ge};
          it_q   <= it_q - 6'd1;
        end else begin
          ci_q <= 2'd0;
          dn_q <= NB'({m_q[0], 14'd0}) + NB'(root_q >> 1);
          dr_q <= NB'(root_q) << 15;
          qt_q <= '0;
          it_q <= 6'd16;
        end
      end
      vna_pkg::ST_DIV: begin
        if (it_q != 6'd0) begin
          if (!dtrial[NB]) begin
            dn_q <= dtrial[NB-1:0];
            qt_q <= {qt_q[14:0], 1'b1};
          end else begin
            qt_q <= {qt_q[14:0], 1'b0};
          end
          dr_q <= dr_q >> 1;
          it_q <= it_q - 6'd1;
        end
      end
      vna_pkg::ST_DIVNEXT: begin
        res_q[ci_q] <= neg_q[ci_q] ? 16'(-qt_q) : qt_q;
        ci_q <= ci_q + 2'd1;
        dn_q <= NB'({m_q[(ci_q == 2'd0) ? 1 : 2], 14'd0}) + NB'(root_q >> 1);
        dr_q <= NB'(root_q) << 15;
        qt_q <= '0;
        it_q <= 6'd16;
      end
      default: ;
    endcase
    if (st_q == vna_pkg::ST_RDWAIT) begin
      big_q <= (magv(cur_sum[0]) > magv(cur_sum[1]))
             ? ((magv(cur_sum[0]) > magv(cur_sum[2])) ? magv(cur_sum[0]) : magv(cur_sum[2]))
             : ((magv(cur_sum[1]) > magv(cur_sum[2])) ? magv(cur_sum[1]) : magv(cur_sum[2]));
    end
    if (st_q == vna_pkg::ST_OUT && out_free) begin
      ox_q    <= res_q[0];
      oy_q    <= res_q[1];
      oz_q    <= res_q[2];
      oread_q <= (job_q.cmd == vna_pkg::CMD_READ);
      ozl_q   <= zl_q;
    end
  end

endmodule

// File: hdl/vertex_normal_accumulator.sv
// write, clear and out-of-range items go straight to the output; a triangle reads its
// three positions, forms the cross product and adds it into three sums; a read of a
// zero sum skips the square root and division of other reads; stalls hold the output
// one item in flight in the back end: no new item until the last result is registered
// a two-entry queue decouples input transfers from the back end
// after reset and each clear the back end sweeps the sum memory before it takes an item
module vertex_normal_accumulator #(
  parameter int unsigned VERTICES      = vna_pkg::VERTICES_DEF,
  parameter int unsigned POSITION_BITS = vna_pkg::POSITION_BITS_DEF,
  parameter int unsigned ACCUM_BITS    = vna_pkg::ACCUM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [1:0]                    command_i,
  input  logic [vna_pkg::IDX_W-1:0]     vertex_a_i,
  input  logic [vna_pkg::IDX_W-1:0]     vertex_b_i,
  input  logic [vna_pkg::IDX_W-1:0]     vertex_c_i,
  input  logic [vna_pkg::IN_POS_W-1:0]  pos_x_i,
  input  logic [vna_pkg::IN_POS_W-1:0]  pos_y_i,
  input  logic [vna_pkg::IN_POS_W-1:0]  pos_z_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [vna_pkg::NRM_W-1:0]     normal_x_o,
  output logic [vna_pkg::NRM_W-1:0]     normal_y_o,
  output logic [vna_pkg::NRM_W-1:0]     normal_z_o,
  output logic                          is_read_data_o,
  output logic                          zero_length_o
);

  logic          job_valid, job_take;
  vna_pkg::job_t job;

  vna_front #(.VERTICES(VERTICES)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .command_i, .vertex_a_i, .vertex_b_i,
    .vertex_c_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .job_valid_o(job_valid), .job_o(job), .job_take_i(job_take));

  vna_back #(.VERTICES(VERTICES), .POSITION_BITS(POSITION_BITS),
             .ACCUM_BITS(ACCUM_BITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_take_o(job_take),
    .valid_o, .stall_i, .normal_x_o, .normal_y_o, .normal_z_o, .is_read_data_o,
    .zero_length_o);

endmodule

// File: tb/sv/vertex_normal_accumulator_checker.sv
module vertex_normal_accumulator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [1:0]  command_i,
  input  logic [9:0]  vertex_a_i,
  input  logic [9:0]  vertex_b_i,
  input  logic [9:0]  vertex_c_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [15:0] normal_x_o,
  input  logic [15:0] normal_y_o,
  input  logic [15:0] normal_z_o,
  input  logic        is_read_data_o,
  input  logic        zero_length_o,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 47);

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        rd;
    logic        zl;
  } normal_res_t;

  longint      pos_tab [1024][3];
  longint      sum_tab [1024][3];
  normal_res_t normals_due [$];
  int          errors = 0;

  assign errors_o  = errors;
  assign pending_o = normals_due.size();

  function automatic longint sat_sum(longint acc, longint inc);
    longint r;
    r = acc + inc;
    if (r > SUM_MAX) r = SUM_MAX;
    if (r < SUM_MIN) r = SUM_MIN;
    return r;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic normal_res_t unit_normal(int idx);
    normal_res_t     res;
    longint unsigned m[3];
    longint unsigned big, acc, len, q;
    logic [15:0]     o[3];
    int              msb;
    res = '0;
    res.rd = 1'b1;
    big = 0;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = sum_tab[idx][i] < 0 ? -sum_tab[idx][i] : sum_tab[idx][i];
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      res.zl = 1'b1;
      return res;
    end
    msb = 0;
    while (msb < 63 && (big >> (msb + 1)) != 0) msb++;
    for (int i = 0; i < 3; i++) begin
      if (msb > 29) m[i] = m[i] >> (msb - 29);
      else m[i] = m[i] << (29 - msb);
      acc += m[i] * m[i];
    end
    len = root_floor(acc);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (len >> 1)) / len;
      o[i] = sum_tab[idx][i] < 0 ? 16'(-q) : 16'(q);
    end
    res.nx = o[0];
    res.ny = o[1];
    res.nz = o[2];
    return res;
  endfunction

  function automatic void apply_command();
    normal_res_t res;
    longint      u[3], v[3], n[3];
    int          corner[3];
    res = '0;
    case (vna_pkg::cmd_e'(command_i))
      vna_pkg::CMD_WRITE: begin
        pos_tab[vertex_a_i][0] = longint'($signed(pos_x_i));
        pos_tab[vertex_a_i][1] = longint'($signed(pos_y_i));
        pos_tab[vertex_a_i][2] = longint'($signed(pos_z_i));
      end
      vna_pkg::CMD_TRI: begin
        corner[0] = vertex_a_i;
        corner[1] = vertex_b_i;
        corner[2] = vertex_c_i;
        for (int i = 0; i < 3; i++) begin
          u[i] = pos_tab[corner[1]][i] - pos_tab[corner[0]][i];
          v[i] = pos_tab[corner[2]][i] - pos_tab[corner[0]][i];
        end
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++)
            sum_tab[corner[k]][i] = sat_sum(sum_tab[corner[k]][i], n[i]);
      end
      vna_pkg::CMD_READ: res = unit_normal(vertex_a_i);
      default: begin
        for (int k = 0; k < 1024; k++)
          for (int i = 0; i < 3; i++) sum_tab[k][i] = 0;
      end
    endcase
    normals_due.insert(normals_due.size(), res);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // handshake inputs only change at the rising edge, so the falling edge sees
  // exactly what the next rising edge will transfer
  always @(negedge clk_i) begin
    normal_res_t want;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (normals_due.size() == 0) begin
          report("unexpected result", 16'd0, 16'd0);
        end else begin
          want = normals_due.pop_front();
          if (normal_x_o !== want.nx) report("normal_x", normal_x_o, want.nx);
          if (normal_y_o !== want.ny) report("normal_y", normal_y_o, want.ny);
          if (normal_z_o !== want.nz) report("normal_z", normal_z_o, want.nz);
          if (is_read_data_o !== want.rd) report("is_read_data", is_read_data_o, want.rd);
          if (zero_length_o !== want.zl) report("zero_length", zero_length_o, want.zl);
        end
      end
      if (valid_i && !stall_o) apply_command();
    end
  end
endmodule

// File: tb/sv/vertex_normal_accumulator_tb.sv
module vertex_normal_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst_n;
  logic        valid_in, stall_in_o, valid_out, stall_out;
  logic [1:0]  command;
  logic [9:0]  va, vb, vc;
  logic [15:0] px, py, pz;
  logic [15:0] nx, ny, nz;
  logic        rd, zl;
  int          errors, pending;
  int          gap_pct, stall_pct;
  bit          written [1024];
  int          written_list [$];

  vertex_normal_accumulator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .valid_i(valid_in), .stall_o(stall_in_o),
    .command_i(command), .vertex_a_i(va), .vertex_b_i(vb), .vertex_c_i(vc),
    .pos_x_i(px), .pos_y_i(py), .pos_z_i(pz),
    .valid_o(valid_out), .stall_i(stall_out),
    .normal_x_o(nx), .normal_y_o(ny), .normal_z_o(nz),
    .is_read_data_o(rd), .zero_length_o(zl)
  );

  vertex_normal_accumulator_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .valid_i(valid_in), .stall_o(stall_in_o),
    .command_i(command), .vertex_a_i(va), .vertex_b_i(vb), .vertex_c_i(vc),
    .pos_x_i(px), .pos_y_i(py), .pos_z_i(pz),
    .valid_o(valid_out), .stall_i(stall_out),
    .normal_x_o(nx), .normal_y_o(ny), .normal_z_o(nz),
    .is_read_data_o(rd), .zero_length_o(zl),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6ms;
    $display("vertex_normal_accumulator_tb: FAIL");
    $finish;
  end

  function automatic int gap_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // receiver side stalls
  initial begin
    int n;
    stall_out = 1'b0;
    @(posedge rst_n);
    forever begin
      n = gap_len(stall_pct);
      if (n > 0) begin
        stall_out <= 1'b1;
        repeat (n) @(posedge clk);
      end
      stall_out <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic send(vna_pkg::cmd_e c, int a, int b, int d, logic [15:0] x, y, z);
    int  n;
    bit  s;
    n = gap_len(gap_pct);
    if (n > 0) begin
      valid_in <= 1'b0;
      repeat (n) @(posedge clk);
    end
    valid_in <= 1'b1;
    command  <= c;
    va <= a[9:0];
    vb <= b[9:0];
    vc <= d[9:0];
    px <= x;
    py <= y;
    pz <= z;
    forever begin
      @(negedge clk);
      s = stall_in_o;
      @(posedge clk);
      if (!s) break;
    end
    if (c == vna_pkg::CMD_WRITE && !written[a]) begin
      written[a] = 1'b1;
      written_list.insert(written_list.size(), a);
    end
  endtask

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_vertex();
    if ($urandom_range(4) != 0) return $urandom_range(15);
    return $urandom_range(1023);
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  initial begin
    int wait_cnt;
    valid_in = 1'b0;
    command  = vna_pkg::CMD_WRITE;
    {va, vb, vc} = '0;
    {px, py, pz} = '0;
    gap_pct   = 30;
    stall_pct = 30;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, repeated corners, zero sums, clear
    send(vna_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_WRITE, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
    send(vna_pkg::CMD_WRITE, 1, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
    send(vna_pkg::CMD_WRITE, 2, 0, 0, 16'h8000, 16'h7fff, 16'h7fff);
    send(vna_pkg::CMD_WRITE, 1023, 0, 0, 16'h7fff, 16'h7fff, 16'h8000);
    send(vna_pkg::CMD_TRI, 0, 1, 2, 0, 0, 0);
    send(vna_pkg::CMD_TRI, 1023, 2, 1, 0, 0, 0);
    send(vna_pkg::CMD_TRI, 0, 0, 1, 0, 0, 0);
    send(vna_pkg::CMD_TRI, 1, 1, 1, 0, 0, 0);
    send(vna_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_READ, 1, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_READ, 2, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_READ, 512, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_CLEAR, 1023, 1023, 1023, 16'hffff, 16'hffff, 16'hffff);
    send(vna_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_TRI, 2, 0, 1, 0, 0, 0);
    send(vna_pkg::CMD_READ, 2, 0, 0, 0, 0, 0);

    for (int i = 0; i < 1000; i++) begin
      if (i % 200 == 0) begin
        gap_pct   = (i % 400 == 0) ? 0 : 40;
        stall_pct = (i % 600 == 0) ? 0 : 40;
      end
      case ($urandom_range(99)) inside
        [0:29]:  send(vna_pkg::CMD_WRITE, pick_vertex(), $urandom_range(1023),
                      $urandom_range(1023), rand_pos(), rand_pos(), rand_pos());
        [30:69]: send(vna_pkg::CMD_TRI, pick_written(), pick_written(), pick_written(),
                      16'($urandom), 16'($urandom), 16'($urandom));
        [70:96]: send(vna_pkg::CMD_READ, pick_vertex(), $urandom_range(1023),
                      $urandom_range(1023), 16'($urandom), 16'($urandom), 16'($urandom));
        default: send(vna_pkg::CMD_CLEAR, $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
    end

    // large sums from extreme corners
    gap_pct   = 0;
    stall_pct = 0;
    send(vna_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_WRITE, 100, 0, 0, 16'h8000, 16'h8000, 16'h0000);
    send(vna_pkg::CMD_WRITE, 101, 0, 0, 16'h7fff, 16'h8000, 16'h0000);
    send(vna_pkg::CMD_WRITE, 102, 0, 0, 16'h8000, 16'h7fff, 16'h0000);
    for (int i = 0; i < 20; i++) send(vna_pkg::CMD_TRI, 100, 101, 102, 0, 0, 0);
    gap_pct   = 30;
    stall_pct = 30;
    send(vna_pkg::CMD_READ, 100, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_READ, 101, 0, 0, 0, 0, 0);
    send(vna_pkg::CMD_READ, 102, 0, 0, 0, 0, 0);
    valid_in <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (2000) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("vertex_normal_accumulator_tb: PASS");
    end else begin
      $display("vertex_normal_accumulator_tb: FAIL");
    end
    $finish;
  end
endmodule
